FILE: src/ttsl_pkg.sv
package ttsl_pkg;

	localparam logic        CMD_LOOKUP  = 1'b0;
	localparam logic        CMD_STORE   = 1'b1;
	localparam logic [1:0]  FLAG_EXACT  = 2'd0;
	localparam logic [7:0]  NO_SQUARE   = 8'd255;
	localparam logic [7:0]  NO_SPECIAL  = 8'd0;
	localparam logic [14:0] MATE_RESET  = 15'd30000;
	localparam logic signed [17:0] MATE_WINDOW = 18'sd1000;
	localparam logic signed [17:0] SAT_MAX     = 18'sd32767;
	localparam logic signed [17:0] SAT_MIN     = -18'sd32768;

	typedef struct packed {
		logic              cmd;
		logic [63:0]       key;
		logic signed [7:0] depth;
		logic [7:0]        ply;
		logic signed [15:0] score;
		logic [1:0]        bound_flag;
		logic [7:0]        generation;
		logic              has_move;
		logic [7:0]        from_square;
		logic [7:0]        to_square;
		logic [7:0]        special_code;
	} ttsl_in_t;

	typedef struct packed {
		logic               hit;
		logic               written;
		logic signed [15:0] entry_score;
		logic signed [15:0] adjusted_score;
		logic signed [7:0]  entry_depth;
		logic [1:0]         entry_flag;
		logic [7:0]         entry_generation;
		logic [7:0]         entry_from;
		logic [7:0]         entry_to;
		logic [7:0]         entry_special;
	} ttsl_out_t;

	typedef struct packed {
		logic signed [15:0] score;
		logic signed [7:0]  depth;
		logic [1:0]         flag;
		logic [7:0]         generation;
		logic [7:0]         from_sq;
		logic [7:0]         to_sq;
		logic [7:0]         special;
	} ttsl_data_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		ttsl_data_t  data;
	} ttsl_row_t;

	typedef struct packed {
		logic rd;
		logic clr;
		logic exec;
	} ttsl_cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} ttsl_state_t;

	// up: push away from zero on store; otherwise pull back on load
	function automatic logic signed [15:0] mate_shift(
		input logic signed [15:0] s,
		input logic [7:0]         ply,
		input logic [14:0]        m,
		input logic               up
	);
		logic signed [17:0] hi;
		logic signed [17:0] lo;
		logic signed [17:0] s18;
		logic signed [17:0] p18;
		logic signed [17:0] sum;
		hi  = $signed({3'b000, m}) - MATE_WINDOW;
		lo  = MATE_WINDOW - $signed({3'b000, m});
		s18 = {{2{s[15]}}, s};
		p18 = $signed({10'd0, ply});
		if (s18 > hi) begin
			sum = up ? s18 + p18 : s18 - p18;
		end else if (s18 < lo) begin
			sum = up ? s18 - p18 : s18 + p18;
		end else begin
			sum = s18;
		end
		if (sum > SAT_MAX) begin
			mate_shift = 16'sh7FFF;
		end else if (sum < SAT_MIN) begin
			mate_shift = 16'sh8000;
		end else begin
			mate_shift = sum[15:0];
		end
	endfunction

endpackage

FILE: src/transposition_table_store_lookup.sv
// The result is registered in the EXEC state that follows the accept cycle; that
// state holds while the previous result still waits in the output register.
// An item is accepted only in the idle state, so no new item is taken until the
// previous one leaves EXEC; the table is read in the accept cycle, written in EXEC.
// Reset: mate_score returns to 30000; a clearing pass then zeroes every slot's valid
// mark, with in_ready low throughout.
module transposition_table_store_lookup
	import ttsl_pkg::*;
#(
	parameter int TABLE_ENTRIES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ttsl_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ttsl_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	ttsl_cmd_t        cmd;
	logic [IDX_W-1:0] clr_addr;

	assign cfg_ready = 1'b1;

	ttsl_ctrl #(
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	ttsl_dp #(
		.ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.clr_addr(clr_addr),
		.in_data (in_data),
		.cfg_we  (cfg_valid),
		.cfg_data(cfg_data),
		.out_data(out_data)
	);

endmodule

FILE: src/ttsl_ctrl.sv
module ttsl_ctrl
	import ttsl_pkg::*;
#(
	parameter int IDX_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output ttsl_cmd_t        cmd,
	output logic [IDX_W-1:0] clr_addr
);

	ttsl_state_t      state_q;
	ttsl_state_t      state_d;
	logic [IDX_W-1:0] clr_idx_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (&clr_idx_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.rd  = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign clr_addr  = clr_idx_q;

endmodule

FILE: src/ttsl_dp.sv
module ttsl_dp
	import ttsl_pkg::*;
#(
	parameter int ENTRIES = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ttsl_cmd_t                    cmd,
	input  logic [$clog2(ENTRIES)-1:0]   clr_addr,
	input  ttsl_in_t                     in_data,
	input  logic                         cfg_we,
	input  logic [14:0]                  cfg_data,
	output ttsl_out_t                    out_data
);

	localparam int IDX_W = $clog2(ENTRIES);

	ttsl_row_t        mem [ENTRIES];
	ttsl_row_t        rd_s1;
	ttsl_in_t         item_s1;
	logic [14:0]      mate_q;
	ttsl_out_t        out_q;

	ttsl_data_t       old_data;
	ttsl_row_t        new_row;
	ttsl_row_t        wr_row;
	ttsl_out_t        res;
	logic             match;
	logic             replace;
	logic             we;
	logic [IDX_W-1:0] wr_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q <= MATE_RESET;
		end else if (cfg_we) begin
			mate_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			item_s1 <= in_data;
			rd_s1   <= mem[in_data.key[IDX_W-1:0]];
		end
		if (we) begin
			mem[wr_addr] <= wr_row;
		end
		if (cmd.exec) begin
			out_q <= res;
		end
	end

	always_comb begin
		old_data = rd_s1.data;
		match    = rd_s1.valid && (rd_s1.key == item_s1.key);
		replace  = !match
			|| ((item_s1.bound_flag == FLAG_EXACT) && (old_data.flag != FLAG_EXACT))
			|| ($signed(item_s1.depth) >= $signed(old_data.depth))
			|| (old_data.generation != item_s1.generation);

		new_row.valid           = 1'b1;
		new_row.key             = item_s1.key;
		new_row.data.score      = mate_shift(item_s1.score, item_s1.ply, mate_q, 1'b1);
		new_row.data.depth      = item_s1.depth;
		new_row.data.flag       = item_s1.bound_flag;
		new_row.data.generation = item_s1.generation;
		if (item_s1.has_move) begin
			new_row.data.from_sq = item_s1.from_square;
			new_row.data.to_sq   = item_s1.to_square;
			new_row.data.special = item_s1.special_code;
		end else begin
			new_row.data.from_sq = NO_SQUARE;
			new_row.data.to_sq   = NO_SQUARE;
			new_row.data.special = NO_SPECIAL;
		end

		res = '0;
		if (item_s1.cmd == CMD_LOOKUP) begin
			if (match) begin
				res.hit              = 1'b1;
				res.entry_score      = old_data.score;
				res.adjusted_score   = mate_shift(old_data.score, item_s1.ply, mate_q, 1'b0);
				res.entry_depth      = old_data.depth;
				res.entry_flag       = old_data.flag;
				res.entry_generation = old_data.generation;
				res.entry_from       = old_data.from_sq;
				res.entry_to         = old_data.to_sq;
				res.entry_special    = old_data.special;
			end
		end else begin
			res.written = replace;
		end

		we      = cmd.clr || (cmd.exec && (item_s1.cmd == CMD_STORE) && replace);
		wr_addr = cmd.clr ? clr_addr : item_s1.key[IDX_W-1:0];
		wr_row  = cmd.clr ? '0 : new_row;
	end

	assign out_data = out_q;

endmodule

FILE: src/ttsl_chk.sv
module ttsl_chk
	import ttsl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input ttsl_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input ttsl_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted on consecutive cycles");

	a_hit_or_written: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.written))
		else $error("hit and written both set");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> (out_data.entry_score == '0)
			&& (out_data.adjusted_score == '0) && (out_data.entry_depth == '0)
			&& (out_data.entry_flag == '0) && (out_data.entry_generation == '0)
			&& (out_data.entry_from == '0) && (out_data.entry_to == '0)
			&& (out_data.entry_special == '0))
		else $error("entry fields set without a hit");

endmodule

bind transposition_table_store_lookup ttsl_chk u_ttsl_chk (.*);
